/* hdl/nmbox_pkg.sv */
// ----------------------------------------------------------------------------
// nmbox_pkg
// Shared types and constants of the nibble mailbox between two CPUs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmbox_pkg;

  // bus access codes carried on in_tuser
  typedef enum logic [2:0] {
    OP_MAIN_MODE_WR = 3'd0,
    OP_MAIN_DATA_WR = 3'd1,
    OP_MAIN_DATA_RD = 3'd2,
    OP_SND_MODE_WR  = 3'd3,
    OP_SND_DATA_WR  = 3'd4,
    OP_SND_DATA_RD  = 3'd5,
    OP_SND_IRQ_REQ  = 3'd6
  } op_t;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned CNT_W  = 2;
  localparam int unsigned OUT_W  = 8;

  // transfer counter values
  localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  // status bit masks
  localparam logic [STAT_W-1:0] STAT_M2S      = 3'b001; // main sent byte
  localparam logic [STAT_W-1:0] STAT_S2M      = 3'b100; // sound sent byte
  localparam logic [STAT_W-1:0] STAT_CLR_S2M  = 3'b011;
  localparam logic [STAT_W-1:0] STAT_CLR_M2S  = 3'b110;

  // one-nibble control commands from the main side
  localparam logic [NIB_W-1:0] CMD_HALT    = 4'h0;
  localparam logic [NIB_W-1:0] CMD_RELEASE = 4'h1;

  // nmi enable patterns in sound mode bits 1-0
  localparam logic [1:0] NMI_EN_CLR = 2'b01;
  localparam logic [1:0] NMI_EN_SET = 2'b10;

  // one result of the mailbox
  typedef struct packed {
    logic             sound_release;
    logic             sound_halt;
    logic             sound_nmi;
    logic             sound_irq;
    logic [NIB_W-1:0] read_data;
  } result_t;

endpackage

`default_nettype wire

/* hdl/nibble_mailbox_between_two_cpus_core.sv */
// ----------------------------------------------------------------------------
// nibble_mailbox_between_two_cpus_core
// Two-sided nibble mailbox between a main CPU and a sound CPU, with
// control pulses and interrupt delivery towards the sound CPU.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+---------
//  in_      | in  | data[7:0]                                   | op[2:0]
//  out_     | out | read_data[3:0], irq, nmi, halt, release     | -
//
//  each request goes from acceptance into the input register, then through
//  the update logic into the result register
//  one request is accepted every cycle while the result side takes them
//  synchronous active-low reset clears all mailbox state and the valid flags of both stages
//  a stalled result holds the input register; in_tready then follows
//  out_tready combinationally
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nibble_mailbox_between_two_cpus_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [nmbox_pkg::DATA_W-1:0]        in_tdata,  // data[7:0]
  input  wire logic [nmbox_pkg::OP_W-1:0]          in_tuser,  // op[2:0]
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // read_data[3:0], sound_irq, sound_nmi, sound_halt, sound_release
  output logic [nmbox_pkg::OUT_W-1:0]              out_tdata
);

  // input register
  logic                             s1_valid_r;
  logic                             s1_valid_nxt;
  nmbox_pkg::op_t                   s1_op_r;
  logic [nmbox_pkg::DATA_W-1:0]     s1_data_r;

  // result register
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  nmbox_pkg::result_t               res_r;
  nmbox_pkg::result_t               res_nxt;

  // mailbox state
  logic [nmbox_pkg::STAT_W-1:0]     status_r,       status_nxt;
  logic                             nmi_en_r,       nmi_en_nxt;
  logic                             irq_pend_r,     irq_pend_nxt;
  logic                             nmi_pend_r,     nmi_pend_nxt;
  logic [nmbox_pkg::CNT_W-1:0]      main_cnt_r,     main_cnt_nxt;
  logic                             main_two_r,     main_two_nxt;
  logic [nmbox_pkg::NIB_W-1:0]      main_low_r,     main_low_nxt;
  logic [nmbox_pkg::CNT_W-1:0]      snd_cnt_r,      snd_cnt_nxt;
  logic                             snd_two_r,      snd_two_nxt;
  logic [nmbox_pkg::NIB_W-1:0]      snd_low_r,      snd_low_nxt;
  logic [nmbox_pkg::DATA_W-1:0]     cmd_byte_r,     cmd_byte_nxt;
  logic [nmbox_pkg::DATA_W-1:0]     reply_byte_r,   reply_byte_nxt;
  logic [nmbox_pkg::NIB_W-1:0]      snd_last_r,     snd_last_nxt;

  logic                             s1_advance;
  logic                             in_accept;
  logic [nmbox_pkg::NIB_W-1:0]      nib;
  logic [nmbox_pkg::CNT_W-1:0]      cnt_dec;
  logic                             deliver;

  // handshake
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  assign nib = s1_data_r[nmbox_pkg::NIB_W-1:0];

  // stage valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // mailbox update for the request in the input register
  always_comb begin
    status_nxt     = status_r;
    nmi_en_nxt     = nmi_en_r;
    irq_pend_nxt   = irq_pend_r;
    nmi_pend_nxt   = nmi_pend_r;
    main_cnt_nxt   = main_cnt_r;
    main_two_nxt   = main_two_r;
    main_low_nxt   = main_low_r;
    snd_cnt_nxt    = snd_cnt_r;
    snd_two_nxt    = snd_two_r;
    snd_low_nxt    = snd_low_r;
    cmd_byte_nxt   = cmd_byte_r;
    reply_byte_nxt = reply_byte_r;
    snd_last_nxt   = snd_last_r;
    res_nxt        = '0;
    cnt_dec        = nmbox_pkg::CNT_ZERO;
    deliver        = 1'b0;

    case (s1_op_r)
      nmbox_pkg::OP_MAIN_MODE_WR: begin
        main_two_nxt = !s1_data_r[2];
        main_cnt_nxt = s1_data_r[2] ? nmbox_pkg::CNT_ONE : nmbox_pkg::CNT_TWO;
        main_low_nxt = '0;
      end
      nmbox_pkg::OP_MAIN_DATA_WR: begin
        if (main_cnt_r != nmbox_pkg::CNT_ZERO) begin
          if (main_cnt_r == nmbox_pkg::CNT_TWO) begin
            main_low_nxt = nib;
          end
          cnt_dec      = main_cnt_r - nmbox_pkg::CNT_ONE;
          main_cnt_nxt = cnt_dec;
          if (cnt_dec == nmbox_pkg::CNT_ZERO) begin
            if (main_two_r) begin
              cmd_byte_nxt = {nib, main_low_r};
              status_nxt   = status_r | nmbox_pkg::STAT_M2S;
              nmi_pend_nxt = 1'b1;
            end else begin
              res_nxt.sound_halt    = (nib == nmbox_pkg::CMD_HALT);
              res_nxt.sound_release = (nib == nmbox_pkg::CMD_RELEASE);
              main_cnt_nxt          = nmbox_pkg::CNT_ONE;
            end
          end
        end
      end
      nmbox_pkg::OP_MAIN_DATA_RD: begin
        if (main_two_r) begin
          // counter saturates at zero
          if (main_cnt_r != nmbox_pkg::CNT_ZERO) begin
            cnt_dec = main_cnt_r - nmbox_pkg::CNT_ONE;
          end
          main_cnt_nxt = cnt_dec;
          status_nxt   = status_r & nmbox_pkg::STAT_CLR_S2M;
          res_nxt.read_data = (cnt_dec == nmbox_pkg::CNT_ONE) ?
                              reply_byte_r[3:0] : reply_byte_r[7:4];
        end else begin
          res_nxt.read_data = {1'b0, status_r};
        end
      end
      nmbox_pkg::OP_SND_MODE_WR: begin
        snd_two_nxt = !s1_data_r[2];
        snd_cnt_nxt = s1_data_r[2] ? nmbox_pkg::CNT_ONE : nmbox_pkg::CNT_TWO;
        snd_low_nxt = '0;
        if (s1_data_r[1:0] == nmbox_pkg::NMI_EN_CLR) begin
          nmi_en_nxt = 1'b0;
        end else if (s1_data_r[1:0] == nmbox_pkg::NMI_EN_SET) begin
          nmi_en_nxt = 1'b1;
        end
      end
      nmbox_pkg::OP_SND_DATA_WR: begin
        deliver = 1'b1;
        if (snd_cnt_r != nmbox_pkg::CNT_ZERO) begin
          if (snd_cnt_r == nmbox_pkg::CNT_TWO) begin
            snd_low_nxt = nib;
          end
          cnt_dec     = snd_cnt_r - nmbox_pkg::CNT_ONE;
          snd_cnt_nxt = cnt_dec;
          if (cnt_dec == nmbox_pkg::CNT_ZERO && snd_two_r) begin
            reply_byte_nxt = {nib, snd_low_r};
            status_nxt     = status_r | nmbox_pkg::STAT_S2M;
          end
        end
      end
      nmbox_pkg::OP_SND_DATA_RD: begin
        deliver = 1'b1;
        if (snd_cnt_r != nmbox_pkg::CNT_ZERO) begin
          if (!snd_two_r) begin
            snd_last_nxt = {1'b0, status_r};
          end else if (snd_cnt_r == nmbox_pkg::CNT_TWO) begin
            snd_last_nxt = cmd_byte_r[3:0];
          end else begin
            snd_last_nxt = cmd_byte_r[7:4];
            status_nxt   = status_r & nmbox_pkg::STAT_CLR_M2S;
          end
          snd_cnt_nxt = snd_cnt_r - nmbox_pkg::CNT_ONE;
        end
        res_nxt.read_data = snd_last_nxt;
      end
      nmbox_pkg::OP_SND_IRQ_REQ: begin
        irq_pend_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    // interrupt delivery on sound-side data access
    if (deliver) begin
      if (irq_pend_r) begin
        res_nxt.sound_irq = 1'b1;
        irq_pend_nxt      = 1'b0;
      end
      if (nmi_pend_nxt && nmi_en_r) begin
        res_nxt.sound_nmi = 1'b1;
        nmi_pend_nxt      = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      status_r     <= '0;
      nmi_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
      nmi_pend_r   <= 1'b0;
      main_cnt_r   <= nmbox_pkg::CNT_ZERO;
      main_two_r   <= 1'b0;
      main_low_r   <= '0;
      snd_cnt_r    <= nmbox_pkg::CNT_ZERO;
      snd_two_r    <= 1'b0;
      snd_low_r    <= '0;
      cmd_byte_r   <= '0;
      reply_byte_r <= '0;
      snd_last_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_advance) begin
        status_r     <= status_nxt;
        nmi_en_r     <= nmi_en_nxt;
        irq_pend_r   <= irq_pend_nxt;
        nmi_pend_r   <= nmi_pend_nxt;
        main_cnt_r   <= main_cnt_nxt;
        main_two_r   <= main_two_nxt;
        main_low_r   <= main_low_nxt;
        snd_cnt_r    <= snd_cnt_nxt;
        snd_two_r    <= snd_two_nxt;
        snd_low_r    <= snd_low_nxt;
        cmd_byte_r   <= cmd_byte_nxt;
        reply_byte_r <= reply_byte_nxt;
        snd_last_r   <= snd_last_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r   <= nmbox_pkg::op_t'(in_tuser);
      s1_data_r <= in_tdata;
    end
    if (s1_advance) begin
      res_r <= res_nxt;
    end
  end

  // status bit 1 is never set
  a_stat_bit1_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !status_r[1])
    else $error("status bit 1 set");

  // main counter never reaches three
  a_main_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    main_cnt_r != 2'd3)
    else $error("main transfer counter out of range");

  // halt and release pulses are exclusive
  a_halt_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.sound_halt && res_r.sound_release))
    else $error("halt and release in one result");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
